FILE: src/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; the including module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Condition that must hold on every rising clk edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

FILE: src/fpa_pkg.sv
// Package for the fixed partition fit allocator: item structs, codes, FSM type.
// No dependencies.
package fpa_pkg;

  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 3;
  localparam int AMOUNT_W = 16;
  localparam int MODE_W   = 2;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic [MODE_W-1:0] FIT_MODE_RESET = MODE_BEST;

  // Register index of fit_mode in the configuration space.
  localparam logic REG_FIT_MODE = 1'b0;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   slot_index;
    logic [AMOUNT_W-1:0] amount;
  } fpa_in_t;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   chosen_slot;
    logic [AMOUNT_W-1:0] leftover;
  } fpa_out_t;

  // Broadcast commands from the sequencer to every cell.
  typedef struct packed {
    logic load;
    logic clear;
    logic take;
  } fpa_ctl_t;

  // Flags of the search token that walks along the cell chain.
  typedef struct packed {
    logic active;
    logic found;
  } fpa_scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } fpa_state_t;

endpackage

FILE: src/fpa_cell.sv
// One partition cell: holds a size and a taken mark, and updates the search token.
// Depends on fpa_pkg.
module fpa_cell
  import fpa_pkg::*;
#(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 3,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fpa_ctl_t             ctl,
  input  logic [IDX_W-1:0]     ctl_index,
  input  logic [SIZE_BITS-1:0] ctl_size,
  input  logic [MODE_W-1:0]    fit_mode,
  input  fpa_scan_t            scan_in,
  input  logic [IDX_W-1:0]     pick_in,
  input  logic [SIZE_BITS-1:0] best_in,
  input  logic [SIZE_BITS-1:0] amt_in,
  output fpa_scan_t            scan_out,
  output logic [IDX_W-1:0]     pick_out,
  output logic [SIZE_BITS-1:0] best_out,
  output logic [SIZE_BITS-1:0] amt_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                 taken;
  logic [SIZE_BITS-1:0] size;
  logic                 fits;
  logic                 better;
  logic                 claim;
  logic [SIZE_BITS-1:0] rest;
  logic                 hit;

  assign hit  = (ctl_index == MY_IDX);
  assign fits = !taken && (size >= amt_in);
  assign rest = size - amt_in;

  // First fit never replaces an earlier find; ties keep the earlier cell.
  always_comb begin
    better = !scan_in.found
          || ((fit_mode == MODE_BEST)  && (rest < best_in))
          || ((fit_mode == MODE_WORST) && (rest > best_in));
    claim  = fits && better;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size  <= '0;
      taken <= 1'b0;
    end else if (ctl.clear) begin
      taken <= 1'b0;
    end else if (ctl.load && hit) begin
      size  <= ctl_size;
      taken <= 1'b0;
    end else if (ctl.take && hit) begin
      taken <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out.active <= scan_in.active;
      scan_out.found  <= scan_in.found || claim;
    end
  end

  always_ff @(posedge clk) begin
    pick_out <= claim ? MY_IDX : pick_in;
    best_out <= claim ? rest : best_in;
    amt_out  <= amt_in;
  end

endmodule

FILE: src/fixed_partition_fit_allocator.sv
// Fixed partition fit allocator, top level: APB register, sequencer, cell chain.
// Depends on fpa_pkg, fpa_cell and assert_macros.svh.
//
// The block keeps NUM_PARTITIONS partitions, each a cell holding a size and a
// taken mark. A load item sets a partition's size and frees it; a load to a
// slot at or above NUM_PARTITIONS is dropped. A clear item frees every
// partition. An allocate item sends a search token down the chain of cells,
// one cell per clock, and no new item is taken until it is done: the token
// passes each cell in turn, then the chosen cell is marked taken and the
// result captured, then the result moves into the output register once that
// register is free. Every allocate item yields exactly one result item;
// loads, clears and opcode 3 yield none. The output register holds a result
// until it is taken while the next item is accepted and searched. fit_mode
// (APB byte address 0) selects first fit (0, and also 3), best fit (1, reset
// value) or worst fit (2); ties go to the lowest index. amount is cut to
// SIZE_BITS bits. Write fit_mode only while no allocate item is in flight.
`include "assert_macros.svh"

module fixed_partition_fit_allocator
  import fpa_pkg::*;
#(
  parameter int NUM_PARTITIONS = 8,
  parameter int SIZE_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  fpa_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output fpa_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

  // Configuration register.
  logic [MODE_W-1:0] fit_mode;

  // Sequencer.
  fpa_state_t state, state_next;
  logic       accept;
  logic       load_ok;
  logic       slot_free;
  fpa_out_t   res;

  // Broadcast to cells.
  fpa_ctl_t             ctl;
  logic [IDX_W-1:0]     ctl_index;
  logic [SIZE_BITS-1:0] req_amt;

  // Width adapters.
  logic [31:0] slot_ext;
  logic [31:0] amt_ext;
  logic [31:0] pick_ext;
  logic [31:0] best_ext;

  // Chain links: entry 0 is driven here, entry NUM_PARTITIONS leaves the last cell.
  fpa_scan_t            link_flags [NUM_PARTITIONS+1];
  logic [IDX_W-1:0]     link_pick  [NUM_PARTITIONS+1];
  logic [SIZE_BITS-1:0] link_best  [NUM_PARTITIONS+1];
  logic [SIZE_BITS-1:0] link_amt   [NUM_PARTITIONS+1];
  logic [NUM_PARTITIONS-1:0] token_vec;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= FIT_MODE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FIT_MODE)) begin
      fit_mode <= pwdata[MODE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_FIT_MODE) ? 32'(fit_mode) : '0;

  // ---------------------------------------------------------- Input decode
  assign slot_ext = 32'(in_data.slot_index);
  assign amt_ext  = 32'(in_data.amount);
  assign req_amt  = amt_ext[SIZE_BITS-1:0];
  assign load_ok  = (slot_ext < 32'(NUM_PARTITIONS));
  // Take a new item only while idle: no search running, no result waiting to move out.
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Output register is free when empty or being emptied this cycle.
  assign slot_free = !out_valid || out_ready;

  // ------------------------------------------------------------ Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl_index  = slot_ext[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        ctl.load  = accept && (in_data.opcode == OP_LOAD) && load_ok;
        ctl.clear = accept && (in_data.opcode == OP_CLEAR);
        if (accept && (in_data.opcode == OP_ALLOC)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Token leaves the last cell: mark the winner taken right away.
        if (link_flags[NUM_PARTITIONS].active) begin
          ctl.take   = link_flags[NUM_PARTITIONS].found;
          ctl_index  = link_pick[NUM_PARTITIONS];
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Inject the search token into the first cell.
  always_comb begin
    link_flags[0].active = accept && (in_data.opcode == OP_ALLOC);
    link_flags[0].found  = 1'b0;
    link_pick[0]         = '0;
    link_best[0]         = '0;
    link_amt[0]          = req_amt;
  end

  // ----------------------------------------------------------- Cell chain
  for (genvar k = 0; k < NUM_PARTITIONS; k++) begin : g_cell
    fpa_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .CELL_IDX  (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .ctl_index (ctl_index),
      .ctl_size  (req_amt),
      .fit_mode  (fit_mode),
      .scan_in   (link_flags[k]),
      .pick_in   (link_pick[k]),
      .best_in   (link_best[k]),
      .amt_in    (link_amt[k]),
      .scan_out  (link_flags[k+1]),
      .pick_out  (link_pick[k+1]),
      .best_out  (link_best[k+1]),
      .amt_out   (link_amt[k+1])
    );
    assign token_vec[k] = link_flags[k+1].active;
  end

  // --------------------------------------------------------------- Result
  assign pick_ext = 32'(link_pick[NUM_PARTITIONS]);
  assign best_ext = 32'(link_best[NUM_PARTITIONS]);

  // Hold the result until the output register frees up.
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && link_flags[NUM_PARTITIONS].active) begin
      if (link_flags[NUM_PARTITIONS].found) begin
        res.granted     <= 1'b1;
        res.chosen_slot <= pick_ext[SLOT_W-1:0];
        res.leftover    <= best_ext[AMOUNT_W-1:0];
      end else begin
        res <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && slot_free) begin
      out_data <= res;
    end
  end

  // ----------------------------------------------------------- Assertions
  `ASSERT_ALWAYS(a_one_token, $onehot0(token_vec),
                 "more than one search token in the cell chain")
  `ASSERT_IMPLIES(a_token_in_scan, link_flags[NUM_PARTITIONS].active, state == ST_SCAN,
                  "search token left the chain outside the scan state")
  `ASSERT_IMPLIES(a_result_from_finish, $rose(out_valid), $past(state) == ST_FINISH,
                  "result item appeared without a finished search")
  `ASSERT_IMPLIES(a_no_grant_zero, out_valid && !out_data.granted,
                  (out_data.chosen_slot == '0) && (out_data.leftover == '0),
                  "refused request carries nonzero slot or leftover")

endmodule

FILE: bench/allocation_checker.sv
`timescale 1ns / 1ps
// Allocation checker: mirrors the partition table, predicts every grant and
// compares it with the block's result items; also checks fit_mode readback. Depends on fpa_pkg.
module allocation_checker
  import fpa_pkg::*;
#(
  parameter int NUM_PARTITIONS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  fpa_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  fpa_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned mismatches,
  output int unsigned grants_waiting
);

  localparam logic [2:0] FIT_MODE_ADDR = {REG_FIT_MODE, 2'b00};

  logic [AMOUNT_W-1:0] part_size [NUM_PARTITIONS];
  logic                part_taken [NUM_PARTITIONS];
  logic [MODE_W-1:0]   mode_shadow;
  fpa_out_t            expected_grants [$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Search the free partitions for the request and take the winner.
  // Only best and worst fit replace an earlier hit; every other code keeps
  // the first one found, which is first fit.
  function automatic fpa_out_t place_request(input logic [AMOUNT_W-1:0] want);
    fpa_out_t            res;
    logic                hit;
    int                  pick;
    logic [AMOUNT_W-1:0] rest;
    logic [AMOUNT_W-1:0] best;
    res  = '0;
    hit  = 1'b0;
    pick = 0;
    best = '0;
    for (int k = 0; k < NUM_PARTITIONS; k++) begin
      if (!part_taken[k] && part_size[k] >= want) begin
        rest = part_size[k] - want;
        if (!hit) begin
          hit  = 1'b1;
          pick = k;
          best = rest;
        end else if (mode_shadow == MODE_BEST && rest < best) begin
          pick = k;
          best = rest;
        end else if (mode_shadow == MODE_WORST && rest > best) begin
          pick = k;
          best = rest;
        end
      end
    end
    if (hit) begin
      part_taken[pick] = 1'b1;
      res.granted      = 1'b1;
      res.chosen_slot  = pick[SLOT_W-1:0];
      res.leftover     = best;
    end
    return res;
  endfunction

  always @(posedge clk) begin : track
    fpa_out_t head;
    if (rst) begin
      mode_shadow = FIT_MODE_RESET;
      for (int k = 0; k < NUM_PARTITIONS; k++) begin
        part_size[k]  = '0;
        part_taken[k] = 1'b0;
      end
      expected_grants.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          flag_mismatch("result with no grant pending", 32'(out_data), '0);
        end else begin
          head = expected_grants.pop_front();
          if (out_data.granted !== head.granted)
            flag_mismatch("granted", 32'(out_data.granted), 32'(head.granted));
          if (out_data.chosen_slot !== head.chosen_slot)
            flag_mismatch("chosen_slot", 32'(out_data.chosen_slot),
                          32'(head.chosen_slot));
          if (out_data.leftover !== head.leftover)
            flag_mismatch("leftover", 32'(out_data.leftover), 32'(head.leftover));
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.opcode)
          OP_LOAD: begin
            if (in_data.slot_index < NUM_PARTITIONS) begin
              part_size[in_data.slot_index]  = in_data.amount;
              part_taken[in_data.slot_index] = 1'b0;
            end
          end
          OP_ALLOC: expected_grants.push_back(place_request(in_data.amount));
          OP_CLEAR: begin
            for (int k = 0; k < NUM_PARTITIONS; k++) part_taken[k] = 1'b0;
          end
          default: ;
        endcase
      end
      if (psel && penable && pready && paddr == FIT_MODE_ADDR) begin
        if (pwrite)
          mode_shadow = pwdata[MODE_W-1:0];
        else if (prdata[MODE_W-1:0] !== mode_shadow)
          flag_mismatch("fit_mode readback", prdata, 32'(mode_shadow));
      end
    end
    grants_waiting <= expected_grants.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the allocator bench: clock, reset, item and register stimulus, verdict.
// Depends on fpa_pkg, fixed_partition_fit_allocator and allocation_checker.
module testbench;
  import fpa_pkg::*;

  localparam int NUM_PARTITIONS = 8;
  localparam int SIZE_BITS      = 16;
  // Codes the package leaves unnamed: the block ignores the opcode and
  // treats the mode as first fit.
  localparam logic [OPCODE_W-1:0] OP_SPARE   = 2'd3;
  localparam logic [MODE_W-1:0]   MODE_SPARE = 2'd3;
  localparam logic [2:0]          FIT_MODE_ADDR = {REG_FIT_MODE, 2'b00};
  // Idle time that drain() waits after the last grant has come back.
  localparam int SETTLE_CYCLES = NUM_PARTITIONS + 8;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 46;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  fpa_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  fpa_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned grants_waiting;
  int unsigned items_sent;
  int unsigned allocs_sent;
  bit          quiet_tx;
  bit          quiet_rx;

  // Every code of the mode register, extremes and the unnamed one included.
  logic [MODE_W-1:0] phase_mode [PHASES] = '{MODE_FIRST, MODE_WORST, MODE_SPARE,
                                             MODE_BEST, MODE_WORST, MODE_FIRST,
                                             MODE_BEST, MODE_SPARE};

  fixed_partition_fit_allocator #(
    .NUM_PARTITIONS(NUM_PARTITIONS),
    .SIZE_BITS     (SIZE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  allocation_checker #(
    .NUM_PARTITIONS(NUM_PARTITIONS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .grants_waiting(grants_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // Partition sizes: mostly a coarse grid so ties and exact fits happen
  // often, with the extremes and full-range values mixed in.
  function automatic int unsigned pick_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 16'hFFFF;
      2, 3:    return $urandom_range(0, 16'hFFFF);
      default: return $urandom_range(1, 16) * 64;
    endcase
  endfunction

  // Requests: aim at the grid above so most hit something, some miss.
  function automatic int unsigned pick_request();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return $urandom_range(0, 16'hFFFF);
      3, 4:    return $urandom_range(0, 1100);
      default: return $urandom_range(1, 16) * 64 - $urandom_range(0, 1) * 32;
    endcase
  endfunction

  // Offer one item: idle a random number of cycles first (none in quiet
  // stretches), then hold valid and payload until the handshake.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input int unsigned slot,
                           input int unsigned amt);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, slot_index: slot[SLOT_W-1:0], amount: amt[AMOUNT_W-1:0]};
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
    if (op == OP_ALLOC) allocs_sent++;
  endtask

  // Stop sending and hold off until every predicted grant has come back,
  // then let the block settle so the mode register can be touched safely.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grants_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the transfer completes on pready.
  task automatic apb_access(input logic write, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= FIT_MODE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: stall a random number of cycles per item (none in quiet
  // stretches), then keep ready up until a result is taken.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = quiet_rx ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int unsigned roll;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst      <= 1'b1;
    quiet_tx    = 1'b0;
    quiet_rx    = 1'b0;
    items_sent  = 0;
    allocs_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Read back the reset mode (best fit) before touching anything.
    apb_access(1'b0, '0);

    // Directed part under best fit: sizes at both extremes and a tie pair.
    send_item(OP_LOAD, 0, 0);
    send_item(OP_LOAD, 1, 16'hFFFF);
    send_item(OP_LOAD, 2, 100);
    send_item(OP_LOAD, 3, 50);
    send_item(OP_LOAD, 4, 200);
    send_item(OP_LOAD, 5, 50);
    send_item(OP_LOAD, 6, 1);
    send_item(OP_LOAD, 7, 16'hAAAA);
    // Zero request lands on the empty partition with nothing left over.
    send_item(OP_ALLOC, 0, 0);
    // Largest request fits only the full-size partition, then nothing.
    send_item(OP_ALLOC, 7, 16'hFFFF);
    send_item(OP_ALLOC, 0, 16'hFFFF);
    // Equal leftovers: the lower index wins, then the other one.
    send_item(OP_ALLOC, 2, 50);
    send_item(OP_ALLOC, 5, 50);
    send_item(OP_ALLOC, 3, 16'h5555);
    // Unknown opcode must leave the table alone.
    send_item(OP_SPARE, 7, 16'hFFFF);
    send_item(OP_ALLOC, 4, 2);
    send_item(OP_CLEAR, 5, 16'h1234);
    send_item(OP_ALLOC, 1, 1);
    send_item(OP_ALLOC, 6, 16'hAAAA);
    send_item(OP_LOAD, 6, 16'h5555);
    send_item(OP_ALLOC, 2, 16'h5555);
    drain();

    // Random phases, each under a mode from phase_mode: clear, refill every partition,
    // then a mix dominated by allocations with loads, clears and noise.
    for (int phase = 0; phase < PHASES; phase++) begin
      apb_access(1'b1, {{(32 - MODE_W){1'b0}}, phase_mode[phase]});
      apb_access(1'b0, '0);
      quiet_tx = (phase % 3 == 1);
      quiet_rx = (phase % 3 == 2);
      send_item(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 16'hFFFF));
      for (int s = 0; s < NUM_PARTITIONS; s++) send_item(OP_LOAD, s, pick_size());
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 14)
          send_item(OP_LOAD, $urandom_range(0, 7), pick_size());
        else if (roll < 19)
          send_item(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 16'hFFFF));
        else if (roll < 24)
          send_item(OP_SPARE, $urandom_range(0, 7), $urandom_range(0, 16'hFFFF));
        else
          send_item(OP_ALLOC, $urandom_range(0, 7), pick_request());
      end
      drain();
    end

    $display("Covered %0d items, %0d of them allocation requests,", items_sent, allocs_sent);
    $display("across all four fit-mode codes with random and back-to-back pacing.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
